>>> rtl/core/kfav_pkg.sv
`default_nettype none
package kfav_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned RW = 31;
    localparam int unsigned DIV_STEPS = 48;

    localparam logic [1:0] REQ_PREDICT = 2'd0;
    localparam logic [1:0] REQ_CORRECT = 2'd1;
    localparam logic [1:0] REQ_RESET   = 2'd2;

    localparam logic signed [QW-1:0] Q_ONE = 32'sd65536;

    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_ANGLE_Q   = 2'd1;
    localparam logic [1:0] CFG_RATE_Q    = 2'd2;
    localparam logic [1:0] CFG_MEAS_R    = 2'd3;

    // Datapath micro-operations, one per controller step.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD_RESET,
        OP_P_X0,
        OP_P_C,
        OP_P_A1,
        OP_P_A2,
        OP_P_A3,
        OP_P_RATE,
        OP_C_S,
        OP_C_Y,
        OP_DIV0_START,
        OP_DIV0_END,
        OP_DIV1_START,
        OP_DIV1_END,
        OP_C_X0,
        OP_C_X1,
        OP_C_P11,
        OP_C_P01,
        OP_C_P00,
        OP_CLEAR_FLAG
    } op_t;

    typedef struct packed {
        op_t op;
        logic mul_start;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_sts_t;

    function automatic logic signed [QW-1:0] sat64(input logic signed [65:0] v,
                                                    output logic clip);
        if (v > 66'sh0_7FFF_FFFF) begin
            clip = 1'b1;
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            clip = 1'b1;
            return 32'sh8000_0000;
        end
        clip = 1'b0;
        return v[QW-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/kfav_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: q = (mag*2^16 + d/2) / d.
module kfav_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [31:0]        num,
    input  wire logic signed [31:0]        den,
    output logic                           busy,
    output logic signed [31:0]             quot,
    output logic                           clip
);
    logic [47:0] dvd_reg, dvd_next;
    logic [47:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] mag;
    logic [47:0] numer;
    logic [33:0] trial;
    logic signed [65:0] sq;

    always_comb begin
        mag = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};
        numer = {mag[31:0], 16'd0} + {17'd0, den[31:1]};
        dvd_next = dvd_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg, dvd_reg[47]} - {2'b0, d_reg};
        if (start) begin
            // mag up to 2^31 shifted by 16 still fits in 48 bits; rem takes mag[32] as carry bit
            dvd_next = numer;
            q_next = '0;
            rem_next = {32'd0, (mag[32] | (mag[31] & 1'b0))};
            d_next = den;
            neg_next = num[31];
            cnt_next = 6'(kfav_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[46:0], 1'b0};
            if (!trial[33]) begin
                rem_next = trial[32:0];
                q_next = {q_reg[46:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], dvd_reg[47]};
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
        sq = neg_reg ? -$signed({18'd0, q_reg}) : $signed({18'd0, q_reg});
        quot = kfav_pkg::sat64(sq, clip);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
endmodule
`default_nettype wire

>>> rtl/core/kfav_datapath.sv
`default_nettype none
module kfav_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire kfav_pkg::dp_cmd_t    cmd,
    input  wire logic signed [31:0]   z,
    input  wire logic [30:0]          dt,
    input  wire logic [30:0]          q00,
    input  wire logic [30:0]          q11,
    input  wire logic [30:0]          r,
    output kfav_pkg::dp_sts_t         sts,
    output logic signed [31:0]        angle,
    output logic                      flag
);
    logic signed [31:0] x0_reg, x1_reg, p00_reg, p01_reg, p11_reg;
    logic signed [31:0] s_reg, y_reg, k0_reg, k1_reg, t_reg;
    logic signed [31:0] o00_reg, o01_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] ma, mb, mq, sum;
    logic signed [31:0] a_in, b_in;
    logic signed [63:0] prod_next;
    logic signed [65:0] pr, ex;
    logic               flag_reg, c_mul, c_sum, c_div;
    logic               div_start, div_busy;
    logic signed [31:0] div_num, div_q;
    logic               sub;

    kfav_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(s_reg), .busy(div_busy), .quot(div_q), .clip(c_div)
    );

    // Multiplier operands per op; product is registered in the cycle before use.
    always_comb begin
        ma = 32'sd0;
        mb = 32'sd0;
        unique case (cmd.op)
            kfav_pkg::OP_P_X0:  begin ma = {1'b0, dt}; mb = x1_reg; end
            kfav_pkg::OP_P_C:   begin ma = {1'b0, dt}; mb = p11_reg; end
            kfav_pkg::OP_P_A1:  begin ma = {1'b0, dt}; mb = p01_reg; end
            kfav_pkg::OP_P_A2:  begin ma = {1'b0, dt}; mb = t_reg; end
            kfav_pkg::OP_C_X0:  begin ma = k0_reg; mb = y_reg; end
            kfav_pkg::OP_C_X1:  begin ma = k1_reg; mb = y_reg; end
            kfav_pkg::OP_C_P11: begin ma = k1_reg; mb = o01_reg; end
            kfav_pkg::OP_C_P01: begin ma = k0_reg; mb = o01_reg; end
            kfav_pkg::OP_C_P00: begin ma = k0_reg; mb = o00_reg; end
            default: ;
        endcase
        prod_next = ma * mb;
        pr = ($signed({{2{prod_reg[63]}}, prod_reg}) + 66'sd32768) >>> 16;
        mq = kfav_pkg::sat64(pr, c_mul);
        a_in = 32'sd0;
        b_in = mq;
        sub = 1'b0;
        unique case (cmd.op)
            kfav_pkg::OP_P_X0:  a_in = x0_reg;
            kfav_pkg::OP_P_C:   a_in = p01_reg;
            kfav_pkg::OP_P_A1:  a_in = p00_reg;
            kfav_pkg::OP_P_A2:  a_in = p00_reg;
            kfav_pkg::OP_P_A3:  begin a_in = p00_reg; b_in = {1'b0, q00}; end
            kfav_pkg::OP_P_RATE: begin a_in = p11_reg; b_in = {1'b0, q11}; end
            kfav_pkg::OP_C_S:   begin a_in = p00_reg; b_in = {1'b0, r}; end
            kfav_pkg::OP_C_Y:   begin a_in = z; b_in = x0_reg; sub = 1'b1; end
            kfav_pkg::OP_C_X0:  a_in = x0_reg;
            kfav_pkg::OP_C_X1:  a_in = x1_reg;
            kfav_pkg::OP_C_P11: begin a_in = p11_reg; sub = 1'b1; end
            kfav_pkg::OP_C_P01: begin a_in = o01_reg; sub = 1'b1; end
            kfav_pkg::OP_C_P00: begin a_in = o00_reg; sub = 1'b1; end
            default: ;
        endcase
        ex = sub ? (66'(a_in) - 66'(b_in)) : (66'(a_in) + 66'(b_in));
        sum = kfav_pkg::sat64(ex, c_sum);
        div_start = (cmd.op == kfav_pkg::OP_DIV0_START) || (cmd.op == kfav_pkg::OP_DIV1_START);
        div_num = (cmd.op == kfav_pkg::OP_DIV0_START) ? p00_reg : p01_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg <= '0; x1_reg <= '0;
            p00_reg <= kfav_pkg::Q_ONE; p01_reg <= '0; p11_reg <= kfav_pkg::Q_ONE;
            flag_reg <= 1'b0;
        end else begin
            // mul_start: operands presented; the sum uses the product next cycle
            if (cmd.mul_start) begin
                prod_reg <= prod_next;
            end else begin
                unique case (cmd.op)
                    kfav_pkg::OP_CLEAR_FLAG: flag_reg <= 1'b0;
                    kfav_pkg::OP_LOAD_RESET: begin
                        x0_reg <= z; x1_reg <= '0; p00_reg <= kfav_pkg::Q_ONE;
                        p01_reg <= '0; p11_reg <= kfav_pkg::Q_ONE;
                    end
                    kfav_pkg::OP_P_X0: begin
                        x0_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    kfav_pkg::OP_P_C: begin
                        t_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    kfav_pkg::OP_P_A1, kfav_pkg::OP_P_A2: begin
                        p00_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    kfav_pkg::OP_P_A3: begin
                        p00_reg <= sum; p01_reg <= t_reg; flag_reg <= flag_reg | c_sum;
                    end
                    kfav_pkg::OP_P_RATE: begin
                        p11_reg <= sum; flag_reg <= flag_reg | c_sum;
                    end
                    kfav_pkg::OP_C_S: begin
                        s_reg <= (sum <= 32'sd0) ? 32'sd1 : sum;
                        flag_reg <= flag_reg | c_sum;
                        o00_reg <= p00_reg; o01_reg <= p01_reg;
                    end
                    kfav_pkg::OP_C_Y: begin
                        y_reg <= sum; flag_reg <= flag_reg | c_sum;
                    end
                    kfav_pkg::OP_DIV0_END: begin
                        k0_reg <= div_q; flag_reg <= flag_reg | c_div;
                    end
                    kfav_pkg::OP_DIV1_END: begin
                        k1_reg <= div_q; flag_reg <= flag_reg | c_div;
                    end
                    kfav_pkg::OP_C_X0: begin
                        x0_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    kfav_pkg::OP_C_X1: begin
                        x1_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    kfav_pkg::OP_C_P11: begin
                        p11_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    kfav_pkg::OP_C_P01: begin
                        p01_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    kfav_pkg::OP_C_P00: begin
                        p00_reg <= sum; flag_reg <= flag_reg | c_mul | c_sum;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign sts.div_busy = div_busy;
    assign angle = x0_reg;
    assign flag = flag_reg;
endmodule
`default_nettype wire

>>> rtl/core/kfav_ctrl.sv
`default_nettype none
module kfav_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_fire,
    input  wire logic [1:0]         req,
    input  wire logic               out_free,
    input  wire kfav_pkg::dp_sts_t  sts,
    output kfav_pkg::dp_cmd_t       cmd,
    output logic                    busy,
    output logic                    done
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_EXEC = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    kfav_pkg::op_t op_reg, op_next;
    logic corr_reg, corr_next;
    logic mul_op;

    always_comb begin
        mul_op = (op_reg == kfav_pkg::OP_P_X0) || (op_reg == kfav_pkg::OP_P_C) ||
                 (op_reg == kfav_pkg::OP_P_A1) || (op_reg == kfav_pkg::OP_P_A2) ||
                 (op_reg == kfav_pkg::OP_C_X0) || (op_reg == kfav_pkg::OP_C_X1) ||
                 (op_reg == kfav_pkg::OP_C_P11) || (op_reg == kfav_pkg::OP_C_P01) ||
                 (op_reg == kfav_pkg::OP_C_P00);
        state_next = state_reg;
        op_next = op_reg;
        corr_next = corr_reg;
        done = 1'b0;
        cmd.op = kfav_pkg::OP_NOP;
        cmd.mul_start = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.op = kfav_pkg::OP_CLEAR_FLAG;
                    corr_next = (req == kfav_pkg::REQ_CORRECT);
                    op_next = (req == kfav_pkg::REQ_RESET) ? kfav_pkg::OP_LOAD_RESET
                                                            : kfav_pkg::OP_P_X0;
                    state_next = (req == kfav_pkg::REQ_RESET) ? S_EXEC : S_MUL;
                end
            end
            S_MUL: begin
                cmd.op = op_reg;
                cmd.mul_start = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.op = op_reg;
                state_next = S_MUL;
                unique case (op_reg)
                    kfav_pkg::OP_LOAD_RESET: begin done = 1'b1; state_next = S_IDLE; end
                    kfav_pkg::OP_P_X0: op_next = kfav_pkg::OP_P_C;
                    kfav_pkg::OP_P_C:  op_next = kfav_pkg::OP_P_A1;
                    kfav_pkg::OP_P_A1: op_next = kfav_pkg::OP_P_A2;
                    kfav_pkg::OP_P_A2: begin op_next = kfav_pkg::OP_P_A3; state_next = S_EXEC; end
                    kfav_pkg::OP_P_A3: begin op_next = kfav_pkg::OP_P_RATE; state_next = S_EXEC; end
                    kfav_pkg::OP_P_RATE: begin
                        if (corr_reg) begin
                            op_next = kfav_pkg::OP_C_S; state_next = S_EXEC;
                        end else begin
                            done = 1'b1; state_next = S_IDLE;
                        end
                    end
                    kfav_pkg::OP_C_S: begin op_next = kfav_pkg::OP_C_Y; state_next = S_EXEC; end
                    kfav_pkg::OP_C_Y: begin op_next = kfav_pkg::OP_DIV0_START; state_next = S_EXEC; end
                    kfav_pkg::OP_DIV0_START: begin
                        op_next = kfav_pkg::OP_DIV0_END; state_next = S_WAIT;
                    end
                    kfav_pkg::OP_DIV0_END: begin
                        op_next = kfav_pkg::OP_DIV1_START; state_next = S_EXEC;
                    end
                    kfav_pkg::OP_DIV1_START: begin
                        op_next = kfav_pkg::OP_DIV1_END; state_next = S_WAIT;
                    end
                    kfav_pkg::OP_DIV1_END: op_next = kfav_pkg::OP_C_X0;
                    kfav_pkg::OP_C_X0:  op_next = kfav_pkg::OP_C_X1;
                    kfav_pkg::OP_C_X1:  op_next = kfav_pkg::OP_C_P11;
                    kfav_pkg::OP_C_P11: op_next = kfav_pkg::OP_C_P01;
                    kfav_pkg::OP_C_P01: op_next = kfav_pkg::OP_C_P00;
                    kfav_pkg::OP_C_P00: begin done = 1'b1; state_next = S_IDLE; end
                    default: state_next = S_IDLE;
                endcase
            end
            S_WAIT: begin
                if (!sts.div_busy) state_next = S_EXEC;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg <= kfav_pkg::OP_NOP;
            corr_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            corr_reg <= corr_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || !out_free;

`ifndef SYNTHESIS
    a_mul_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |=> state_reg == S_EXEC) else $error("mul step not followed");
    a_mul_op: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |-> mul_op) else $error("mul step without product");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> state_reg == S_IDLE) else $error("done outside end of item");
`endif
endmodule
`default_nettype wire

>>> rtl/core/kalman_filter_angle_velocity.sv
`default_nettype none
// Two-state (angle, rate) Kalman filter, constant-velocity model, Q16.16.
// Input stream s_*: one word per request. s_axis_tdata[31:0] holds the
// sample angle; s_axis_tuser[1:0] holds the request kind (predict,
// predict and correct, reset to angle; code 3 acts as predict).
// Output stream m_*: one word per request. m_axis_tdata[31:0] holds the
// filtered angle; m_axis_tuser[0] is set when any value clipped.
// Configuration: cfg_we, cfg_index, cfg_wdata write dt, angle noise,
// rate noise and measurement noise; write only while idle.
// A predict-and-correct request runs the 48-step restoring divider twice,
// once for each of the two gains, and every product goes through the
// single shared multiplier, each product registered.
// One request is processed at a time; s_axis_tready drops from acceptance
// until the result word has left the output register.
// Reset (aresetn low, synchronous) restores default registers, zero
// estimates and unit covariance, and empties the output register.
// When the receiver stalls, hold the result word; no new word is taken.
module kalman_filter_angle_velocity (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] sample_value
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] filtered_angle
    output logic             m_axis_tuser,  // [0] saturated
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_wdata
);
    logic [30:0] dt_reg, q00_reg, q11_reg, r_reg;
    logic signed [31:0] z_reg;
    logic [31:0] out_data_reg;
    logic out_user_reg, out_valid_reg;
    logic in_fire, busy, done, flag;
    logic done_d_reg;
    logic signed [31:0] angle;
    kfav_pkg::dp_cmd_t cmd;
    kfav_pkg::dp_sts_t sts;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy;

    // Configuration registers; zero measurement noise is stored as one LSB.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= 31'd2185;
            q00_reg <= 31'd655;
            q11_reg <= 31'd6554;
            r_reg <= 31'd327680;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kfav_pkg::CFG_TIME_STEP: dt_reg <= cfg_wdata;
                kfav_pkg::CFG_ANGLE_Q:   q00_reg <= cfg_wdata;
                kfav_pkg::CFG_RATE_Q:    q11_reg <= cfg_wdata;
                kfav_pkg::CFG_MEAS_R:    r_reg <= (cfg_wdata == 31'd0) ? 31'd1 : cfg_wdata;
                default: ;
            endcase
        end
    end

    // Latch the sample word for the whole request.
    always_ff @(posedge aclk) begin
        if (in_fire) z_reg <= s_axis_tdata;
    end

    // The output side counts as occupied from done until the word is taken.
    kfav_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .req(s_axis_tuser),
        .out_free(!(out_valid_reg || done_d_reg)), .sts(sts), .cmd(cmd), .busy(busy),
        .done(done)
    );

    kfav_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .z(z_reg), .dt(dt_reg),
        .q00(q00_reg), .q11(q11_reg), .r(r_reg), .sts(sts), .angle(angle), .flag(flag)
    );

    // Output register: raise valid together with the data load, hold until
    // the receiver takes the word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done_d_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

    // Result appears in state registers in the cycle after done, so load late.
    always_ff @(posedge aclk) begin
        if (!aresetn) done_d_reg <= 1'b0;
        else done_d_reg <= done;
    end
    always_ff @(posedge aclk) begin
        if (done_d_reg) begin
            out_data_reg <= angle;
            out_user_reg <= flag;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_axis_tready) else $error("word taken while result pending");
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        done_d_reg |=> out_valid_reg) else $error("result not presented");
`endif
endmodule
`default_nettype wire

>>> tb/sv/tb_kalman_filter_angle_velocity.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_kalman_filter_angle_velocity;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 200;

    typedef struct packed {
        logic signed [31:0] angle;
        logic               clipped;
    } angle_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] sample_value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] filtered_angle
    logic        m_axis_tuser;        // [0] saturated
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_wdata = '0;

    always #6 aclk = ~aclk;

    kalman_filter_angle_velocity u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the filter: registers and state.
    logic [30:0]        dt_q, angle_q, rate_q, meas_r;
    logic signed [31:0] est_angle, est_rate, p_aa, p_ar, p_rr;
    bit                 clip_seen;

    angle_word_t expected_angles[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    // Idling levels in percent; hold_off_left forces a long receiver stall.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off_left = 0;

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF) begin
            clip_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -66'sh0_8000_0000) begin
            clip_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qsum(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return clip32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] qdiff(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return clip32(66'(a) - 66'(b));
    endfunction

    // Round to nearest, ties upward: arithmetic shift floors.
    function automatic logic signed [31:0] qprod(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b) + 66'sd32768;
        return clip32(p >>> 16);
    endfunction

    // Gain quotient: magnitude rounded half away from zero, sign restored.
    function automatic logic signed [31:0] qgain(input logic signed [31:0] num,
                                                 input logic signed [31:0] den);
        logic [63:0]        mag, q;
        logic signed [65:0] s;
        mag = num < 0 ? 64'(-(65'(num))) : 64'(num);
        q = ((mag << 16) + 64'(den) / 2) / 64'(den);
        s = num < 0 ? -66'(q) : 66'(q);
        return clip32(s);
    endfunction

    task automatic model_reset();
        dt_q = 31'd2185; angle_q = 31'd655; rate_q = 31'd6554; meas_r = 31'd327680;
        est_angle = 0; est_rate = 0; p_aa = kfav_pkg::Q_ONE; p_ar = 0;
        p_rr = kfav_pkg::Q_ONE;
    endtask

    // Work out the filtered angle for one request and queue it.
    task automatic predict_angle(input logic [1:0] req, input logic signed [31:0] z);
        logic signed [31:0] dt, c, p00, s, y, k0, k1, o00, o01, o11;
        clip_seen = 1'b0;
        if (req == kfav_pkg::REQ_RESET) begin
            est_angle = z; est_rate = 0; p_aa = kfav_pkg::Q_ONE; p_ar = 0;
            p_rr = kfav_pkg::Q_ONE;
        end else begin
            dt = $signed({1'b0, dt_q});
            est_angle = qsum(est_angle, qprod(dt, est_rate));
            c = qsum(p_ar, qprod(dt, p_rr));
            p00 = qsum(p_aa, qprod(dt, p_ar));
            p00 = qsum(p00, qprod(dt, c));
            p_aa = qsum(p00, $signed({1'b0, angle_q}));
            p_ar = c;
            p_rr = qsum(p_rr, $signed({1'b0, rate_q}));
            if (req == kfav_pkg::REQ_CORRECT) begin
                s = qsum(p_aa, $signed({1'b0, meas_r}));
                if (s <= 0) s = 1;
                y = qdiff(z, est_angle);
                k0 = qgain(p_aa, s);
                k1 = qgain(p_ar, s);
                est_angle = qsum(est_angle, qprod(k0, y));
                est_rate = qsum(est_rate, qprod(k1, y));
                o00 = p_aa; o01 = p_ar; o11 = p_rr;
                p_rr = qdiff(o11, qprod(k1, o01));
                p_ar = qdiff(o01, qprod(k0, o01));
                p_aa = qdiff(o00, qprod(k0, o00));
            end
        end
        expected_angles.push_back('{angle: est_angle, clipped: clip_seen});
    endtask

    // Offer one word, hold it until taken, then update the shadow filter.
    // Wait for a clock edge first so valid is never driven twice in one step.
    task automatic send_request(input logic [1:0] req, input logic [31:0] sample);
        @(posedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= sample;
        do @(posedge aclk); while (!s_axis_tready);
        predict_angle(req, sample);
        s_axis_tvalid <= 1'b0;
    endtask

    // Drain, then let the block settle before touching registers.
    task automatic wait_drained();
        while (expected_angles.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            kfav_pkg::CFG_TIME_STEP: dt_q = val;
            kfav_pkg::CFG_ANGLE_Q:   angle_q = val;
            kfav_pkg::CFG_RATE_Q:    rate_q = val;
            kfav_pkg::CFG_MEAS_R:    meas_r = (val == 0) ? 31'd1 : val;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1, 0) ? 32'h7FFF_FFFF - $urandom_range(255)
                                           : 32'h8000_0000 + $urandom_range(255);
            default: return 32'($signed($urandom_range(20 << 16))) - (10 << 16);
        endcase
    endfunction

    // Mostly correct requests with occasional random resets so the filter stays in range.
    task automatic random_requests(input int n);
        logic [1:0] req;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0:       req = kfav_pkg::REQ_RESET;
                1:       req = 2'd3;
                2, 3, 4: req = kfav_pkg::REQ_PREDICT;
                default: req = kfav_pkg::REQ_CORRECT;
            endcase
            send_request(req, rand_sample());
        end
    endtask

    task automatic test_directed();
        send_request(kfav_pkg::REQ_PREDICT, 32'h0);
        send_request(kfav_pkg::REQ_CORRECT, 32'h0001_0000);
        send_request(kfav_pkg::REQ_CORRECT, 32'h7FFF_FFFF);
        send_request(kfav_pkg::REQ_CORRECT, 32'h8000_0000);
        send_request(2'd3, 32'hFFFF_FFFF);
        send_request(kfav_pkg::REQ_RESET, 32'h7FFF_FFFF);
        send_request(kfav_pkg::REQ_PREDICT, 32'h0);
        send_request(kfav_pkg::REQ_RESET, 32'h8000_0000);
        send_request(kfav_pkg::REQ_CORRECT, 32'h7FFF_FFFF);
        send_request(kfav_pkg::REQ_RESET, 32'hFFFF_FFFF);
        send_request(kfav_pkg::REQ_CORRECT, 32'h5555_5555);
        send_request(kfav_pkg::REQ_CORRECT, 32'hAAAA_AAAA);
        wait_drained();
        // Huge step and noise: drives saturation and a non-positive S.
        write_reg(kfav_pkg::CFG_TIME_STEP, 31'h7FFF_FFFF);
        write_reg(kfav_pkg::CFG_ANGLE_Q, 31'h7FFF_FFFF);
        write_reg(kfav_pkg::CFG_RATE_Q, 31'h7FFF_FFFF);
        write_reg(kfav_pkg::CFG_MEAS_R, 31'h7FFF_FFFF);
        send_request(kfav_pkg::REQ_RESET, 32'h0001_0000);
        send_request(kfav_pkg::REQ_CORRECT, 32'h0002_0000);
        send_request(kfav_pkg::REQ_CORRECT, 32'h8000_0000);
        send_request(kfav_pkg::REQ_PREDICT, 32'h0);
        wait_drained();
        // Zero noise written: measurement noise must become one LSB.
        write_reg(kfav_pkg::CFG_TIME_STEP, 31'd0);
        write_reg(kfav_pkg::CFG_ANGLE_Q, 31'd0);
        write_reg(kfav_pkg::CFG_RATE_Q, 31'd0);
        write_reg(kfav_pkg::CFG_MEAS_R, 31'd0);
        send_request(kfav_pkg::REQ_RESET, 32'h0003_0000);
        send_request(kfav_pkg::REQ_CORRECT, 32'hFFFD_0000);
        send_request(kfav_pkg::REQ_PREDICT, 32'h0);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(kfav_pkg::CFG_TIME_STEP,
                      phase == 0 ? 31'd2185 : 31'($urandom_range(1 << 17)));
            write_reg(kfav_pkg::CFG_ANGLE_Q, 31'($urandom_range(1 << 18)));
            write_reg(kfav_pkg::CFG_RATE_Q, 31'($urandom_range(1 << 18)));
            write_reg(kfav_pkg::CFG_MEAS_R,
                      phase == 3 ? 31'($urandom()) : 31'($urandom_range(1 << 20)));
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase
            send_request(kfav_pkg::REQ_RESET, 32'h0);
            random_requests(430);
            wait_drained();
        end
    endtask

    task automatic test_back_pressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_left = 600;
        random_requests(10);
        // Pause until every result is back, then carry on.
        while (expected_angles.size() != 0) @(posedge aclk);
        random_requests(10);
        wait_drained();
    endtask

    // Receiver ready: random stalls plus an occasional long hold-off.
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge aclk) begin
        angle_word_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_angles.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word angle=%h sat=%b", $time,
                         m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_angles.pop_front();
                if (m_axis_tdata !== want.angle) begin
                    error_count++;
                    $display("%0t: angle expected %h actual %h", $time, want.angle,
                             m_axis_tdata);
                end
                if (m_axis_tuser !== want.clipped) begin
                    error_count++;
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.clipped, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_settings();
        test_back_pressure();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_angles.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
